// File: hdl/thpc_pkg.sv
// ---------------------------------------------------------------------------
// thpc_pkg
// Shared types, codes and constants of the hex/text pane cursor block.
// ---------------------------------------------------------------------------
package thpc_pkg;

  // field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;

  // command queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // special characters
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  // register reset values
  localparam logic [ROW_W-1:0] TOP_ROW_RST     = 5'd3;
  localparam logic [ROW_W-1:0] BOTTOM_ROW_RST  = 5'd10;
  localparam logic [COL_W-1:0] LAST_COLUMN_RST = 6'd29;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_HEX_MODE    = 2'd0;
  localparam logic [1:0] REG_TOP_ROW     = 2'd1;
  localparam logic [1:0] REG_BOTTOM_ROW  = 2'd2;
  localparam logic [1:0] REG_LAST_COLUMN = 2'd3;

  // write kinds
  localparam logic WK_CELL  = 1'b0;
  localparam logic WK_CLEAR = 1'b1;

  // input opcodes
  localparam logic OP_DISPLAY = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef struct packed {
    logic             hex_mode;
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
    logic [COL_W-1:0] last_column;
  } cfg_t;

  // request class decided by the front
  typedef enum logic [2:0] {
    K_CLEAR = 3'd0,
    K_CR    = 3'd1,
    K_LF    = 3'd2,
    K_TEXT  = 3'd3,
    K_HEX   = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] byte_value;
    logic              buffer_end;
  } cmd_t;

  typedef struct packed {
    logic              write_kind;
    logic [COL_W-1:0]  cell_column;
    logic [ROW_W-1:0]  cell_row;
    logic [BYTE_W-1:0] char_code;
    logic              last_of_item;
    logic              buffer_done;
  } result_t;

  // back-end sequencer phases
  typedef enum logic [2:0] {
    PH_HEAD  = 3'b001,
    PH_LO    = 3'b010,
    PH_SPACE = 3'b100
  } phase_t;

  // uppercase ascii hex digit
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] base;
    base = (nib < 4'd10) ? 8'h30 : 8'h37;
    return base + {4'b0000, nib};
  endfunction

endpackage

// File: hdl/thpc_if.sv
// ---------------------------------------------------------------------------
// thpc_in_if / thpc_out_if
// Valid/ready channels for incoming bytes and outgoing pane writes.
// ---------------------------------------------------------------------------
interface thpc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [thpc_pkg::BYTE_W-1:0] byte_value;
  logic                        buffer_end;

  modport source (output valid, output opcode, output byte_value, output buffer_end,
                  input ready);
  modport sink   (input valid, input opcode, input byte_value, input buffer_end,
                  output ready);
endinterface

interface thpc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        write_kind;
  logic [thpc_pkg::COL_W-1:0]  cell_column;
  logic [thpc_pkg::ROW_W-1:0]  cell_row;
  logic [thpc_pkg::BYTE_W-1:0] char_code;
  logic                        last_of_item;
  logic                        buffer_done;

  modport source (output valid, output write_kind, output cell_column, output cell_row,
                  output char_code, output last_of_item, output buffer_done,
                  input ready);
  modport sink   (input valid, input write_kind, input cell_column, input cell_row,
                  input char_code, input last_of_item, input buffer_done,
                  output ready);
endinterface

// File: hdl/thpc_regs.sv
// ---------------------------------------------------------------------------
// thpc_regs
// APB-style configuration registers: mode and pane geometry.
// ---------------------------------------------------------------------------
module thpc_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [thpc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [thpc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [thpc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output thpc_pkg::cfg_t                  cfg
);
  import thpc_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hex_mode    <= 1'b0;
      cfg_r.top_row     <= TOP_ROW_RST;
      cfg_r.bottom_row  <= BOTTOM_ROW_RST;
      cfg_r.last_column <= LAST_COLUMN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HEX_MODE:    cfg_r.hex_mode    <= pwdata[0];
        REG_TOP_ROW:     cfg_r.top_row     <= pwdata[ROW_W-1:0];
        REG_BOTTOM_ROW:  cfg_r.bottom_row  <= pwdata[ROW_W-1:0];
        REG_LAST_COLUMN: cfg_r.last_column <= pwdata[COL_W-1:0];
        default:         cfg_r.hex_mode    <= cfg_r.hex_mode;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_HEX_MODE:    prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.hex_mode};
      REG_TOP_ROW:     prdata = {{(CFG_DATA_W-ROW_W){1'b0}}, cfg_r.top_row};
      REG_BOTTOM_ROW:  prdata = {{(CFG_DATA_W-ROW_W){1'b0}}, cfg_r.bottom_row};
      REG_LAST_COLUMN: prdata = {{(CFG_DATA_W-COL_W){1'b0}}, cfg_r.last_column};
      default:         prdata = '0;
    endcase
  end

endmodule

// File: hdl/thpc_front.sv
// ---------------------------------------------------------------------------
// thpc_front
// Accepts input requests and classifies them into back-end commands.
// ---------------------------------------------------------------------------
module thpc_front (
  thpc_in_if.sink         in_ch,
  input  logic            hex_mode,
  input  logic            queue_full,
  output logic            push,
  output thpc_pkg::cmd_t  push_cmd
);
  import thpc_pkg::*;

  cmd_kind_t kind;

  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid & !queue_full;

  // classify the request
  always_comb begin
    priority if (in_ch.opcode == OP_CLEAR) begin
      kind = K_CLEAR;
    end else if (in_ch.byte_value == CH_CR) begin
      kind = K_CR;
    end else if (in_ch.byte_value == CH_LF) begin
      kind = K_LF;
    end else if (hex_mode) begin
      kind = K_HEX;
    end else begin
      kind = K_TEXT;
    end
  end

  assign push_cmd.kind       = kind;
  assign push_cmd.byte_value = in_ch.byte_value;
  assign push_cmd.buffer_end = in_ch.buffer_end;

endmodule

// File: hdl/thpc_cmd_queue.sv
// ---------------------------------------------------------------------------
// thpc_cmd_queue
// Short command queue that decouples the front from the back sequencer.
// ---------------------------------------------------------------------------
module thpc_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  thpc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output thpc_pkg::cmd_t head_cmd
);
  import thpc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_pop;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_pop     = pop & head_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: hdl/thpc_back.sv
// ---------------------------------------------------------------------------
// thpc_back
// Cursor sequencer: turns commands into pane writes, at most one per cycle, none while the output stalls.
// ---------------------------------------------------------------------------
module thpc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  thpc_pkg::cfg_t cfg,
  input  logic           head_valid,
  input  thpc_pkg::cmd_t head_cmd,
  output logic           pop,
  thpc_out_if.source     out_ch
);
  import thpc_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             pend_r, pend_nxt;
  phase_t           phase_r, phase_nxt;
  logic             out_valid_r;
  result_t          out_r;

  logic             step;
  logic             emit;
  result_t          res;
  logic [ROW_W:0]   row_inc;
  logic             row_wrap;
  logic [ROW_W-1:0] nr_row;
  logic [COL_W:0]   adv_sum;
  logic             col_wrap;
  logic             is_crlf;

  assign step    = head_valid & (!out_valid_r | out_ch.ready);
  assign is_crlf = (head_cmd.kind == K_CR) || (head_cmd.kind == K_LF);

  // row advance with wrap to the top row
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign row_wrap = row_inc > {1'b0, cfg.bottom_row};
  assign nr_row   = row_wrap ? cfg.top_row : row_inc[ROW_W-1:0];

  // column advance: two after the hex digits, one otherwise
  assign adv_sum  = {1'b0, col_r} + ((phase_r == PH_LO) ? 7'd2 : 7'd1);
  assign col_wrap = adv_sum > {1'b0, cfg.last_column};

  // sequencer step
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    pend_nxt  = pend_r;
    phase_nxt = phase_r;
    pop       = 1'b0;
    emit      = 1'b0;
    res.write_kind   = WK_CELL;
    res.cell_column  = col_r;
    res.cell_row     = row_r;
    res.char_code    = CH_SPACE;
    res.last_of_item = 1'b0;
    res.buffer_done  = 1'b0;
    if (step) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (head_cmd.kind == K_CLEAR) begin
            // clear request: home the cursor, pending flag kept
            emit             = 1'b1;
            res.write_kind   = WK_CLEAR;
            res.cell_column  = '0;
            res.cell_row     = cfg.top_row;
            res.last_of_item = 1'b1;
            col_nxt          = '0;
            row_nxt          = cfg.top_row;
            pop              = 1'b1;
          end else if (pend_r) begin
            // pending clear goes out first, the byte stays at the head
            emit             = 1'b1;
            res.write_kind   = WK_CLEAR;
            res.cell_column  = '0;
            res.cell_row     = cfg.top_row;
            res.last_of_item = is_crlf;
            col_nxt          = '0;
            row_nxt          = cfg.top_row;
            pend_nxt         = 1'b0;
          end else begin
            unique case (head_cmd.kind)
              K_CR: begin
                col_nxt = '0;
                pop     = 1'b1;
              end
              K_LF: begin
                row_nxt  = nr_row;
                pend_nxt = pend_r | row_wrap;
                pop      = 1'b1;
              end
              K_TEXT: begin
                emit             = 1'b1;
                res.char_code    = head_cmd.byte_value;
                res.last_of_item = 1'b1;
                pop              = 1'b1;
                if (col_wrap) begin
                  col_nxt  = '0;
                  row_nxt  = nr_row;
                  pend_nxt = pend_r | row_wrap;
                end else begin
                  col_nxt = adv_sum[COL_W-1:0];
                end
              end
              K_HEX: begin
                emit          = 1'b1;
                res.char_code = hex_char(head_cmd.byte_value[7:4]);
                phase_nxt     = PH_LO;
              end
              default: begin
                pop = 1'b1;
              end
            endcase
          end
        end
        PH_LO: begin
          // low digit one column on, wrap check after both digits
          emit            = 1'b1;
          res.cell_column = col_r + 1'b1;
          res.char_code   = hex_char(head_cmd.byte_value[3:0]);
          phase_nxt       = PH_SPACE;
          if (col_wrap) begin
            col_nxt  = '0;
            row_nxt  = nr_row;
            pend_nxt = pend_r | row_wrap;
          end else begin
            col_nxt = adv_sum[COL_W-1:0];
          end
        end
        PH_SPACE: begin
          emit             = 1'b1;
          res.last_of_item = 1'b1;
          pop              = 1'b1;
          phase_nxt        = PH_HEAD;
          if (col_wrap) begin
            col_nxt  = '0;
            row_nxt  = nr_row;
            pend_nxt = pend_r | row_wrap;
          end else begin
            col_nxt = adv_sum[COL_W-1:0];
          end
        end
        default: begin
          phase_nxt = PH_HEAD;
        end
      endcase
    end
    res.buffer_done = res.last_of_item & head_cmd.buffer_end;
  end

  // cursor and phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= TOP_ROW_RST;
      pend_r  <= 1'b0;
      phase_r <= PH_HEAD;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
      phase_r <= phase_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.write_kind   = out_r.write_kind;
  assign out_ch.cell_column  = out_r.cell_column;
  assign out_ch.cell_row     = out_r.cell_row;
  assign out_ch.char_code    = out_r.char_code;
  assign out_ch.last_of_item = out_r.last_of_item;
  assign out_ch.buffer_done  = out_r.buffer_done;

endmodule

// File: hdl/text_hex_pane_cursor.sv
// Path: a request's first pane write passes through the command queue and the output register.
// Throughput: at most one pane write per cycle, none while the output stalls; a text
// byte gives 1 write, a hex byte 3, a CR or LF none, a pending clear adds 1 (up to 4).
// A 4-entry command queue lets input be taken while the sequencer or output stalls.
// Reset (synchronous, active low): cursor to column 0 row 3, no clear pending,
// queue and output empty, registers to text mode, rows 3..10, last column 29.
// ---------------------------------------------------------------------------
// text_hex_pane_cursor
// Places received bytes into a character pane as cell writes and clears.
// ---------------------------------------------------------------------------
module text_hex_pane_cursor (
  input  logic                            clk,
  input  logic                            rst_n,
  thpc_in_if.sink                         in_ch,
  thpc_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [thpc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [thpc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [thpc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import thpc_pkg::*;

  cfg_t cfg;
  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // configuration registers
  thpc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // request intake and classification
  thpc_front u_front (
    .in_ch      (in_ch),
    .hex_mode   (cfg.hex_mode),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // command queue
  thpc_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // cursor sequencer and output register
  thpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
